// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// clocked checks shared by the biquad top level and sequencer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every rising edge outside reset
`define BQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check at every rising edge, reset included
`define BQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/bq_pkg.sv =====
// ---------------------------------------------------------------------------
// biquad filter package
// widths, microcode fields and the control program of the biquad filter
// ---------------------------------------------------------------------------
package bq_pkg;

    localparam int COEF_FRAC_BITS = 24;
    localparam int SAMPLE_W       = 32;
    localparam int COEF_W         = 32;
    localparam int STATE_W        = 48;
    localparam int SPLIT_W        = STATE_W / 2;
    localparam int HALF_W         = SPLIT_W + 1;
    localparam int PROD_W         = COEF_W + HALF_W;
    localparam int ACC_W          = COEF_W + STATE_W + 4;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_STEPS      = 14;
    localparam int STEP_W         = $clog2(NUM_STEPS);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
    localparam logic [STEP_W-1:0] WAIT_STEP = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_ONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_TWO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_TWO  = 3'd4;

    localparam logic [COEF_W-1:0] FF_COEF_ZERO_RST = COEF_W'(32'd16777216);

    // step conditions
    localparam logic [1:0] COND_NEXT = 2'd0;
    localparam logic [1:0] COND_IN   = 2'd1;
    localparam logic [1:0] COND_OUT  = 2'd2;

    // coefficient select
    localparam logic [2:0] COEF_A1 = 3'd0;
    localparam logic [2:0] COEF_A2 = 3'd1;
    localparam logic [2:0] COEF_B0 = 3'd2;
    localparam logic [2:0] COEF_B1 = 3'd3;
    localparam logic [2:0] COEF_B2 = 3'd4;

    // operand select
    localparam logic [1:0] SRC_Z1 = 2'd0;
    localparam logic [1:0] SRC_Z2 = 2'd1;
    localparam logic [1:0] SRC_W  = 2'd2;

    // accumulator operations
    localparam logic [2:0] ACC_NOP    = 3'd0;
    localparam logic [2:0] ACC_LOAD_X = 3'd1;
    localparam logic [2:0] ACC_ADD_LO = 3'd2;
    localparam logic [2:0] ACC_ADD_HI = 3'd3;
    localparam logic [2:0] ACC_SUB_LO = 3'd4;
    localparam logic [2:0] ACC_SUB_HI = 3'd5;
    localparam logic [2:0] ACC_SAT_W  = 3'd6;
    localparam logic [2:0] ACC_SAT_Y  = 3'd7;

    typedef struct packed {
        logic [1:0]        cond;
        logic              jump;
        logic [STEP_W-1:0] target;
        logic [2:0]        coef_sel;
        logic [1:0]        src_sel;
        logic              hi;
        logic [2:0]        acc_op;
    } t_ctrl;

    typedef struct packed {
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
    } t_coefs;

    function automatic t_ctrl mk_word(logic [1:0] cond, logic jump, logic [STEP_W-1:0] target,
                                      logic [2:0] coef_sel, logic [1:0] src_sel, logic hi,
                                      logic [2:0] acc_op);
        t_ctrl c;
        c.cond     = cond;
        c.jump     = jump;
        c.target   = target;
        c.coef_sel = coef_sel;
        c.src_sel  = src_sel;
        c.hi       = hi;
        c.acc_op   = acc_op;
        return c;
    endfunction

    // control program: the product of one step is accumulated in the next
    function automatic t_ctrl ucode(logic [STEP_W-1:0] step);
        t_ctrl c;
        case (step)
            4'd0:    c = mk_word(COND_IN,   1'b0, '0, COEF_A1, SRC_Z1, 1'b0, ACC_LOAD_X);
            4'd1:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_A1, SRC_Z1, 1'b1, ACC_SUB_LO);
            4'd2:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_A2, SRC_Z2, 1'b0, ACC_SUB_HI);
            4'd3:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_A2, SRC_Z2, 1'b1, ACC_SUB_LO);
            4'd4:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_A1, SRC_Z1, 1'b0, ACC_SUB_HI);
            4'd5:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_A1, SRC_Z1, 1'b0, ACC_SAT_W);
            4'd6:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_B0, SRC_W,  1'b0, ACC_NOP);
            4'd7:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_B0, SRC_W,  1'b1, ACC_ADD_LO);
            4'd8:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_B1, SRC_Z1, 1'b0, ACC_ADD_HI);
            4'd9:    c = mk_word(COND_NEXT, 1'b0, '0, COEF_B1, SRC_Z1, 1'b1, ACC_ADD_LO);
            4'd10:   c = mk_word(COND_NEXT, 1'b0, '0, COEF_B2, SRC_Z2, 1'b0, ACC_ADD_HI);
            4'd11:   c = mk_word(COND_NEXT, 1'b0, '0, COEF_B2, SRC_Z2, 1'b1, ACC_ADD_LO);
            4'd12:   c = mk_word(COND_NEXT, 1'b0, '0, COEF_B2, SRC_Z2, 1'b0, ACC_ADD_HI);
            4'd13:   c = mk_word(COND_OUT,  1'b1, WAIT_STEP, COEF_B2, SRC_Z2, 1'b0, ACC_SAT_Y);
            default: c = mk_word(COND_NEXT, 1'b1, WAIT_STEP, COEF_A1, SRC_Z1, 1'b0, ACC_NOP);
        endcase
        return c;
    endfunction

endpackage

// ===== design/biquad_iir_filter_top.sv =====
// a result is registered into the output register at the last program step
// a new item is taken only after the last one has passed every step, since the single shared multiplier
//   works through ten 32x25 partial products per item
// a result waiting in the output register stalls the last step only
// reset: synchronous, active low; delay line clears to zero, b0 to unity
// ---------------------------------------------------------------------------
// biquad iir filter top level
// direct form II biquad, coefficient registers and output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_iir_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [bq_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [bq_pkg::SAMPLE_W-1:0] o_sample_out
);

    bq_pkg::t_ctrl                   ctrl;
    bq_pkg::t_coefs                  r_coefs;
    logic                            go;
    logic                            out_free;
    logic                            y_fire;
    logic [bq_pkg::SAMPLE_W-1:0]     y;
    logic                            r_out_valid;
    logic [bq_pkg::SAMPLE_W-1:0]     r_sample_out;

    assign o_cfg_ready  = 1'b1;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (ctrl.cond != bq_pkg::COND_IN);
    assign y_fire       = go && ctrl.acc_op == bq_pkg::ACC_SAT_Y;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
            r_coefs.b0 <= bq_pkg::FF_COEF_ZERO_RST;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bq_pkg::REG_FB_COEF_ONE:  r_coefs.a1 <= i_cfg_data;
                bq_pkg::REG_FB_COEF_TWO:  r_coefs.a2 <= i_cfg_data;
                bq_pkg::REG_FF_COEF_ZERO: r_coefs.b0 <= i_cfg_data;
                bq_pkg::REG_FF_COEF_ONE:  r_coefs.b1 <= i_cfg_data;
                bq_pkg::REG_FF_COEF_TWO:  r_coefs.b2 <= i_cfg_data;
                default:                  r_coefs <= r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (y_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (y_fire) begin
            r_sample_out <= y;
        end
    end

    bq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_go       (go)
    );

    bq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_go     (go),
        .i_coefs  (r_coefs),
        .i_sample (i_sample_in),
        .o_y      (y)
    );

    `BQ_ASSERT(a_out_source, $rose(o_out_valid) |-> $past(y_fire), "result without final step")
    `BQ_ASSERT(a_no_overwrite, (y_fire && r_out_valid) |-> !i_out_stall, "waiting result overwritten")

endmodule

// ===== design/bq_seq.sv =====
// ---------------------------------------------------------------------------
// biquad sequencer
// step counter over the control program, with wait conditions and jumps
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bq_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    output bq_pkg::t_ctrl o_ctrl,
    output logic          o_go
);

    logic [bq_pkg::STEP_W-1:0] r_step;
    logic [bq_pkg::STEP_W-1:0] n_step;
    bq_pkg::t_ctrl             ctrl;

    assign ctrl   = bq_pkg::ucode(r_step);
    assign o_ctrl = ctrl;

    always_comb begin
        case (ctrl.cond)
            bq_pkg::COND_NEXT: o_go = 1'b1;
            bq_pkg::COND_IN:   o_go = i_in_valid;
            bq_pkg::COND_OUT:  o_go = i_out_free;
            default:           o_go = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (o_go) begin
            n_step = ctrl.jump ? ctrl.target : r_step + bq_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bq_pkg::WAIT_STEP;
        end else begin
            r_step <= n_step;
        end
    end

    `BQ_ASSERT(a_step_range, (r_step <= bq_pkg::LAST_STEP), "step counter out of range")
    `BQ_ASSERT(a_wrap, (r_step == bq_pkg::LAST_STEP && o_go) |=> (r_step == bq_pkg::WAIT_STEP), "no return to wait step")
    `BQ_ASSERT(a_advance, (r_step != bq_pkg::WAIT_STEP && r_step != bq_pkg::LAST_STEP) |=> (r_step == $past(r_step) + bq_pkg::STEP_W'(1)), "step skipped")

endmodule

// ===== design/bq_dp.sv =====
// ---------------------------------------------------------------------------
// biquad datapath
// shared 32x25 multiplier, wide accumulator, saturation and delay line
// ---------------------------------------------------------------------------
module bq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bq_pkg::t_ctrl                 i_ctrl,
    input  logic                          i_go,
    input  bq_pkg::t_coefs                i_coefs,
    input  logic [bq_pkg::SAMPLE_W-1:0]   i_sample,
    output logic [bq_pkg::SAMPLE_W-1:0]   o_y
);

    logic signed [bq_pkg::COEF_W-1:0]  coef;
    logic        [bq_pkg::STATE_W-1:0] operand;
    logic signed [bq_pkg::HALF_W-1:0]  half;
    logic signed [bq_pkg::PROD_W-1:0]  prod;
    logic signed [bq_pkg::PROD_W-1:0]  r_prod;
    logic signed [bq_pkg::ACC_W-1:0]   prod_lo;
    logic signed [bq_pkg::ACC_W-1:0]   prod_hi;
    logic signed [bq_pkg::ACC_W-1:0]   x_ext;
    logic signed [bq_pkg::ACC_W-1:0]   r_acc;
    logic signed [bq_pkg::ACC_W-1:0]   shifted;
    logic        [bq_pkg::STATE_W-1:0] w_sat;
    logic        [bq_pkg::STATE_W-1:0] r_w;
    logic        [bq_pkg::STATE_W-1:0] r_z1;
    logic        [bq_pkg::STATE_W-1:0] r_z2;

    always_comb begin
        case (i_ctrl.coef_sel)
            bq_pkg::COEF_A1: coef = i_coefs.a1;
            bq_pkg::COEF_A2: coef = i_coefs.a2;
            bq_pkg::COEF_B0: coef = i_coefs.b0;
            bq_pkg::COEF_B1: coef = i_coefs.b1;
            bq_pkg::COEF_B2: coef = i_coefs.b2;
            default:         coef = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.src_sel)
            bq_pkg::SRC_Z1: operand = r_z1;
            bq_pkg::SRC_Z2: operand = r_z2;
            bq_pkg::SRC_W:  operand = r_w;
            default:        operand = '0;
        endcase
    end

    // low half unsigned, high half signed
    assign half = i_ctrl.hi ? {operand[bq_pkg::STATE_W-1], operand[bq_pkg::STATE_W-1:bq_pkg::SPLIT_W]}
                            : {1'b0, operand[bq_pkg::SPLIT_W-1:0]};
    assign prod = coef * half;

    assign prod_lo = bq_pkg::ACC_W'(r_prod);
    assign prod_hi = prod_lo <<< bq_pkg::SPLIT_W;
    assign x_ext   = bq_pkg::ACC_W'($signed(i_sample)) <<< bq_pkg::COEF_FRAC_BITS;
    assign shifted = r_acc >>> bq_pkg::COEF_FRAC_BITS;

    always_comb begin
        if (&shifted[bq_pkg::ACC_W-1:bq_pkg::STATE_W-1] || ~|shifted[bq_pkg::ACC_W-1:bq_pkg::STATE_W-1]) begin
            w_sat = shifted[bq_pkg::STATE_W-1:0];
        end else if (shifted[bq_pkg::ACC_W-1]) begin
            w_sat = {1'b1, {(bq_pkg::STATE_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(bq_pkg::STATE_W-1){1'b1}}};
        end
    end

    always_comb begin
        if (&shifted[bq_pkg::ACC_W-1:bq_pkg::SAMPLE_W-1] || ~|shifted[bq_pkg::ACC_W-1:bq_pkg::SAMPLE_W-1]) begin
            o_y = shifted[bq_pkg::SAMPLE_W-1:0];
        end else if (shifted[bq_pkg::ACC_W-1]) begin
            o_y = {1'b1, {(bq_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(bq_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_go) begin
            case (i_ctrl.acc_op)
                bq_pkg::ACC_LOAD_X: r_acc <= x_ext;
                bq_pkg::ACC_ADD_LO: r_acc <= r_acc + prod_lo;
                bq_pkg::ACC_ADD_HI: r_acc <= r_acc + prod_hi;
                bq_pkg::ACC_SUB_LO: r_acc <= r_acc - prod_lo;
                bq_pkg::ACC_SUB_HI: r_acc <= r_acc - prod_hi;
                bq_pkg::ACC_SAT_W: begin
                    r_acc <= '0;
                    r_w   <= w_sat;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    // delay line moves when the result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1 <= '0;
            r_z2 <= '0;
        end else if (i_go && i_ctrl.acc_op == bq_pkg::ACC_SAT_Y) begin
            r_z1 <= r_w;
            r_z2 <= r_z1;
        end
    end

endmodule

// ===== tb/tb_biquad_iir_filter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquad iir filter testbench
// drives samples and coefficient writes into the direct form II biquad,
// predicts each filtered sample with its own fixed point model of the filter
// and compares every output item in order, under random gaps and stalls
// ---------------------------------------------------------------------------
module tb_biquad_iir_filter_top;

    localparam int RESULT_LATENCY = 14;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 75;
    localparam int NUM_PHASES     = 8;

    localparam logic signed [31:0] VAL_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] UNITY     = 32'sd1 <<< bq_pkg::COEF_FRAC_BITS;
    localparam logic signed [31:0] GENTLE_A1 = -32'sd26843546;
    localparam logic signed [31:0] GENTLE_A2 = 32'sd10737418;

    typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} press_e;
    typedef enum int {PROF_GENTLE, PROF_RANDOM, PROF_EXTREME, PROF_MIXED} profile_e;

    class biquad_scoreboard;
        logic signed [bq_pkg::COEF_W-1:0]   coef [5];
        logic signed [bq_pkg::STATE_W-1:0]  delay_one;
        logic signed [bq_pkg::STATE_W-1:0]  delay_two;
        logic signed [bq_pkg::SAMPLE_W-1:0] filtered_due [$];
        int                                 n_fail;

        function new();
            coef[bq_pkg::REG_FB_COEF_ONE]  = '0;
            coef[bq_pkg::REG_FB_COEF_TWO]  = '0;
            coef[bq_pkg::REG_FF_COEF_ZERO] = bq_pkg::FF_COEF_ZERO_RST;
            coef[bq_pkg::REG_FF_COEF_ONE]  = '0;
            coef[bq_pkg::REG_FF_COEF_TWO]  = '0;
            delay_one = '0;
            delay_two = '0;
            n_fail    = 0;
        endfunction

        function void write_coef(logic [bq_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bq_pkg::COEF_W-1:0] data);
            if (idx <= bq_pkg::REG_FF_COEF_TWO) begin
                coef[idx] = data;
            end
        endfunction

        function logic signed [127:0] clamp_to(logic signed [127:0] v, int n);
            logic signed [127:0] top;
            logic signed [127:0] bottom;
            top    = (128'sd1 <<< (n - 1)) - 128'sd1;
            bottom = -(128'sd1 <<< (n - 1));
            if (v > top) return top;
            if (v < bottom) return bottom;
            return v;
        endfunction

        function logic signed [bq_pkg::SAMPLE_W-1:0] next_filtered(
            logic signed [bq_pkg::SAMPLE_W-1:0] x);
            logic signed [127:0] sum;
            logic signed [127:0] z1;
            logic signed [127:0] z2;
            logic signed [127:0] mid;
            logic signed [127:0] y;
            z1  = delay_one;
            z2  = delay_two;
            sum = x;
            sum = (sum <<< bq_pkg::COEF_FRAC_BITS) - coef[bq_pkg::REG_FB_COEF_ONE] * z1
                  - coef[bq_pkg::REG_FB_COEF_TWO] * z2;
            mid = clamp_to(sum >>> bq_pkg::COEF_FRAC_BITS, bq_pkg::STATE_W);
            sum = coef[bq_pkg::REG_FF_COEF_ZERO] * mid + coef[bq_pkg::REG_FF_COEF_ONE] * z1
                  + coef[bq_pkg::REG_FF_COEF_TWO] * z2;
            y   = clamp_to(sum >>> bq_pkg::COEF_FRAC_BITS, bq_pkg::SAMPLE_W);
            delay_two = delay_one;
            delay_one = mid[bq_pkg::STATE_W-1:0];
            return y[bq_pkg::SAMPLE_W-1:0];
        endfunction

        function void note_sample(logic signed [bq_pkg::SAMPLE_W-1:0] x);
            filtered_due.push_back(next_filtered(x));
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            n_fail++;
        endtask

        task check_output(logic signed [bq_pkg::SAMPLE_W-1:0] got);
            logic signed [bq_pkg::SAMPLE_W-1:0] want;
            if (filtered_due.size() == 0) begin
                report($sformatf("output item %0d with nothing outstanding", got));
            end else begin
                want = filtered_due.pop_front();
                if (got !== want) begin
                    report($sformatf("sample_out got %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [bq_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [bq_pkg::COEF_W-1:0]          i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [bq_pkg::SAMPLE_W-1:0] i_sample_in;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [bq_pkg::SAMPLE_W-1:0] o_sample_out;

    biquad_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int holds_asked;
    int holds_done;
    int quiet_cycles;

    biquad_iir_filter_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // accepted items and register writes feed the scoreboard, which checks each accepted output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_coef(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_sample(i_sample_in);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_output(o_sample_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: random stalls plus the occasional long hold-off
    initial begin : out_side
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [bq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bq_pkg::COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_coefs(input logic signed [31:0] a1, input logic signed [31:0] a2,
                               input logic signed [31:0] b0, input logic signed [31:0] b1,
                               input logic signed [31:0] b2);
        write_reg(bq_pkg::REG_FB_COEF_ONE, a1);
        write_reg(bq_pkg::REG_FB_COEF_TWO, a2);
        write_reg(bq_pkg::REG_FF_COEF_ZERO, b0);
        write_reg(bq_pkg::REG_FF_COEF_ONE, b1);
        write_reg(bq_pkg::REG_FF_COEF_TWO, b2);
        // an index past the last register must be ignored
        write_reg(bq_pkg::CFG_IDX_W'($urandom_range(2 ** bq_pkg::CFG_IDX_W - 1,
                                                    bq_pkg::REG_FF_COEF_TWO + 1)),
                  $urandom);
    endtask

    task automatic offer_sample(input logic signed [bq_pkg::SAMPLE_W-1:0] x);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.filtered_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(4))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return UNITY;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_sample();
        int v;
        case ($urandom_range(9))
            0:       v = pick_extreme();
            1, 2, 3: v = $urandom;
            default: v = int'($urandom_range(65535)) - 32768;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] rand_around(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic load_profile(input profile_e prof);
        logic signed [31:0] b0;
        case (prof)
            PROF_GENTLE: begin
                write_coefs(GENTLE_A1, GENTLE_A2, rand_around(1 << 24), rand_around(1 << 24),
                            rand_around(1 << 24));
            end
            PROF_RANDOM: begin
                write_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
            end
            PROF_EXTREME: begin
                write_coefs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                            pick_extreme());
            end
            default: begin
                // symmetric feedforward, b2 equal to b0
                b0 = rand_around(1 << 26);
                write_coefs(rand_around(1 << 23), rand_around(1 << 23), b0,
                            rand_around(1 << 26), b0);
            end
        endcase
    endtask

    task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct,
                             input press_e press);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2) begin
                if (press == PRESS_HOLD) begin
                    holds_asked++;
                end else if (press == PRESS_PAUSE) begin
                    wait_results();
                end
            end
            offer_sample(rand_sample());
        end
        wait_results();
    endtask

    initial begin : stimulus
        int idle_pct;
        int stall_pct;
        press_e press;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_sample_in    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked    = 0;
        holds_done     = 0;
        quiet_cycles   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: unity pass-through
        offer_sample(32'sd0);
        offer_sample(32'sd1);
        offer_sample(-32'sd1);
        offer_sample(VAL_MAX);
        offer_sample(VAL_MIN);
        offer_sample(32'sh5555_5555);
        offer_sample(32'shAAAA_AAAA);
        wait_results();

        // runaway feedback: state and output both saturate, both signs
        write_coefs(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
        for (int k = 0; k < 8; k++) begin
            offer_sample(k[0] ? VAL_MIN : VAL_MAX);
        end
        wait_results();
        write_coefs(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
        for (int k = 0; k < 5; k++) begin
            offer_sample(VAL_MAX);
        end
        wait_results();

        // all zero: output held at zero
        write_coefs(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        offer_sample(VAL_MAX);
        offer_sample(VAL_MIN);
        offer_sample(32'sd12345);
        wait_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            load_profile(profile_e'(p % 4));
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            if (p == 0 || p == 5) begin
                press = PRESS_HOLD;
            end else if (p == 1 || p == 6) begin
                press = PRESS_PAUSE;
            end else begin
                press = PRESS_NONE;
            end
            run_phase(PHASE_ITEMS, idle_pct, stall_pct, press);
        end

        wait_results();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (sb.n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/bq_pkg.sv
design/bq_seq.sv
design/bq_dp.sv
design/biquad_iir_filter_top.sv
tb/tb_biquad_iir_filter_top.sv
